### rtl/core/ll1ep_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ll1ep_pkg
// Shared types, symbol codes and predictive tables of the expression parser.
// ----------------------------------------------------------------------------
package ll1ep_pkg;

   localparam int STACK_DEPTH_DEF = 64;
   localparam int SYM_W           = 4;
   localparam int TOKEN_W         = 4;
   localparam int DEPTH_W         = 7;
   localparam int STATUS_W        = 2;
   localparam int GUARD_W         = 5;
   localparam int REQ_DATA_W      = 8;
   localparam int RSP_DATA_W      = 16;

   localparam logic [GUARD_W-1:0] GUARD_LIMIT = 5'd16;

   // terminals share their codes with the token encoding
   localparam logic [SYM_W-1:0] SYM_A     = 4'd0;
   localparam logic [SYM_W-1:0] SYM_PLUS  = 4'd1;
   localparam logic [SYM_W-1:0] SYM_MINUS = 4'd2;
   localparam logic [SYM_W-1:0] SYM_MUL   = 4'd3;
   localparam logic [SYM_W-1:0] SYM_DIV   = 4'd4;
   localparam logic [SYM_W-1:0] SYM_LPAR  = 4'd5;
   localparam logic [SYM_W-1:0] SYM_RPAR  = 4'd6;
   localparam logic [SYM_W-1:0] SYM_END   = 4'd7;
   localparam logic [SYM_W-1:0] SYM_E     = 4'd8;
   localparam logic [SYM_W-1:0] SYM_Q     = 4'd9;
   localparam logic [SYM_W-1:0] SYM_T     = 4'd10;
   localparam logic [SYM_W-1:0] SYM_R     = 4'd11;
   localparam logic [SYM_W-1:0] SYM_F     = 4'd12;

   typedef enum logic [STATUS_W-1:0] {
      ST_MATCH    = 2'd0,
      ST_ACCEPT   = 2'd1,
      ST_REJECT   = 2'd2,
      ST_OVERFLOW = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      P_BLANK = 4'd0,
      P_TQ    = 4'd1,
      P_PTQ   = 4'd2,
      P_MTQ   = 4'd3,
      P_FR    = 4'd4,
      P_XFR   = 4'd5,
      P_DFR   = 4'd6,
      P_A     = 4'd7,
      P_PAREN = 4'd8,
      P_EPS   = 4'd9
   } prod_type;

   typedef enum logic [2:0] {
      EV_MATCH,
      EV_ACCEPT,
      EV_REJECT,
      EV_OVERFLOW,
      EV_EXPAND,
      EV_EPSILON
   } ev_type;

   typedef struct packed {
      logic load;
      logic init0;
      logic init1;
      logic read;
      logic hold;
      logic fault;
      logic eval;
      logic push;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic   finished;
      logic   fault;
      ev_type outcome;
      logic   push_last;
      logic   out_free;
   } stat_type;

   // rows E Q T R F, columns a + - * / ( ) $
   function automatic prod_type predict(input logic [SYM_W-1:0] nt,
                                        input logic [TOKEN_W-1:0] tok);
      prod_type p;
      p = P_BLANK;
      unique case (nt)
         SYM_E: if (tok == SYM_A || tok == SYM_LPAR) p = P_TQ;
         SYM_Q: begin
            case (tok) inside
               SYM_PLUS:          p = P_PTQ;
               SYM_MINUS:         p = P_MTQ;
               SYM_RPAR, SYM_END: p = P_EPS;
               default:           p = P_BLANK;
            endcase
         end
         SYM_T: if (tok == SYM_A || tok == SYM_LPAR) p = P_FR;
         SYM_R: begin
            case (tok) inside
               SYM_MUL:                               p = P_XFR;
               SYM_DIV:                               p = P_DFR;
               SYM_PLUS, SYM_MINUS, SYM_RPAR, SYM_END: p = P_EPS;
               default:                               p = P_BLANK;
            endcase
         end
         SYM_F: begin
            if (tok == SYM_A) p = P_A;
            else if (tok == SYM_LPAR) p = P_PAREN;
         end
         default: p = P_BLANK;
      endcase
      return p;
   endfunction

   function automatic logic [1:0] rhs_len(input prod_type p);
      logic [1:0] n;
      unique case (p) inside
         P_TQ, P_FR:                          n = 2'd2;
         P_PTQ, P_MTQ, P_XFR, P_DFR, P_PAREN: n = 2'd3;
         P_A:                                 n = 2'd1;
         default:                             n = 2'd0;
      endcase
      return n;
   endfunction

   // symbol i of the right-hand side, leftmost first
   function automatic logic [SYM_W-1:0] rhs_sym(input prod_type p, input logic [1:0] i);
      logic [SYM_W-1:0] s;
      s = SYM_A;
      unique case (p)
         P_TQ:    s = (i == 2'd0) ? SYM_T : SYM_Q;
         P_FR:    s = (i == 2'd0) ? SYM_F : SYM_R;
         P_PTQ:   s = (i == 2'd0) ? SYM_PLUS  : (i == 2'd1) ? SYM_T : SYM_Q;
         P_MTQ:   s = (i == 2'd0) ? SYM_MINUS : (i == 2'd1) ? SYM_T : SYM_Q;
         P_XFR:   s = (i == 2'd0) ? SYM_MUL   : (i == 2'd1) ? SYM_F : SYM_R;
         P_DFR:   s = (i == 2'd0) ? SYM_DIV   : (i == 2'd1) ? SYM_F : SYM_R;
         P_PAREN: s = (i == 2'd0) ? SYM_LPAR  : (i == 2'd1) ? SYM_E : SYM_RPAR;
         default: s = SYM_A;
      endcase
      return s;
   endfunction

endpackage
`default_nettype wire

### rtl/core/ll1ep_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ll1ep_ctrl
// Sequencer of the parser: stack init, top fetch, evaluate, push, result.
// ----------------------------------------------------------------------------
module ll1ep_ctrl
   import ll1ep_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     req_tvalid,
   output logic          req_tready,
   input  wire logic     req_new_string,
   input  wire stat_type stat,
   output cmd_type       cmd
);

   typedef enum logic [6:0] {
      S_INIT0 = 7'b0000001,
      S_INIT1 = 7'b0000010,
      S_IDLE  = 7'b0000100,
      S_READ  = 7'b0001000,
      S_EVAL  = 7'b0010000,
      S_PUSH  = 7'b0100000,
      S_DONE  = 7'b1000000
   } state_type;

   state_type state_ff, state_in;
   logic      have_item_ff, have_item_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT0;
         have_item_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         have_item_ff <= have_item_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      have_item_in = have_item_ff;
      cmd          = '0;
      req_tready   = 1'b0;
      unique case (state_ff)
         S_INIT0: begin
            cmd.init0 = 1'b1;
            state_in  = S_INIT1;
         end
         S_INIT1: begin
            cmd.init1 = 1'b1;
            state_in  = have_item_ff ? S_READ : S_IDLE;
         end
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load     = 1'b1;
               have_item_in = 1'b1;
               state_in     = req_new_string ? S_INIT0 : S_READ;
            end
         end
         S_READ: begin
            if (stat.finished) begin
               cmd.hold = 1'b1;
               state_in = S_DONE;
            end else if (stat.fault) begin
               cmd.fault = 1'b1;
               state_in  = S_DONE;
            end else begin
               cmd.read = 1'b1;
               state_in = S_EVAL;
            end
         end
         S_EVAL: begin
            cmd.eval = 1'b1;
            case (stat.outcome)
               EV_EXPAND:  state_in = S_PUSH;
               EV_EPSILON: state_in = S_READ;
               default:    state_in = S_DONE;
            endcase
         end
         S_PUSH: begin
            cmd.push = 1'b1;
            if (stat.push_last) state_in = S_READ;
         end
         S_DONE: begin
            if (stat.out_free) begin
               cmd.emit     = 1'b1;
               have_item_in = 1'b0;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_INIT0;
      endcase
   end

endmodule
`default_nettype wire

### rtl/core/ll1ep_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ll1ep_datapath
// Symbol stack memory, stack pointer, table lookup and result register.
// ----------------------------------------------------------------------------
module ll1ep_datapath
   import ll1ep_pkg::*;
#(
   parameter int STACK_DEPTH = STACK_DEPTH_DEF
)(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic [TOKEN_W-1:0]    req_token,
   input  wire cmd_type               cmd,
   output stat_type                   stat,
   input  wire logic                  rsp_tready,
   output logic                       rsp_tvalid,
   output logic [RSP_DATA_W-1:0]      rsp_tdata
);

   localparam int AW  = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int SPW = $clog2(STACK_DEPTH + 1);
   localparam logic [SPW:0]   DEPTH_P1  = (SPW + 1)'(STACK_DEPTH + 1);
   localparam logic [SPW-1:0] DEPTH_MAX = SPW'(STACK_DEPTH);
   localparam int WW = SPW + DEPTH_W;

   logic [SYM_W-1:0] stack_mem [STACK_DEPTH];

   // control state
   logic [SPW-1:0]           sp_ff, sp_in;
   logic                     finished_ff, finished_in;
   status_type               last_ff, last_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   // payload
   logic [TOKEN_W-1:0]       token_ff, token_in;
   logic [GUARD_W-1:0]       guard_ff, guard_in;
   logic [SYM_W-1:0]         top_ff;
   prod_type                 prod_ff, prod_in;
   logic [1:0]               idx_ff, idx_in;
   status_type               res_ff, res_in;
   logic [RSP_DATA_W-1:0]    rsp_data_ff, rsp_data_in;

   logic [SPW-1:0]           sp_m1;
   logic                     mem_we;
   logic [AW-1:0]            mem_waddr;
   logic [SYM_W-1:0]         mem_wdata;
   prod_type                 prod;
   logic [1:0]               n_len;
   ev_type                   outcome;
   logic [WW-1:0]            sp_wide;
   logic [DEPTH_W-1:0]       depth_sat;

   assign sp_m1 = sp_ff - SPW'(1);

   always_ff @(posedge clock) begin
      if (mem_we) stack_mem[mem_waddr] <= mem_wdata;
      if (cmd.read) top_ff <= stack_mem[sp_m1[AW-1:0]];
   end

   always_comb begin
      mem_we    = cmd.init0 | cmd.init1 | cmd.push;
      mem_waddr = sp_ff[AW-1:0];
      mem_wdata = rhs_sym(prod_ff, idx_ff - 2'd1);
      if (cmd.init0) begin
         mem_waddr = '0;
         mem_wdata = SYM_END;
      end else if (cmd.init1) begin
         mem_waddr = AW'(1);
         mem_wdata = SYM_E;
      end
   end

   // evaluate the fetched top against the current token
   always_comb begin
      prod  = predict(top_ff, token_ff);
      n_len = rhs_len(prod);
      if (top_ff == SYM_END) begin
         outcome = (token_ff == SYM_END) ? EV_ACCEPT : EV_REJECT;
      end else if (top_ff < SYM_END) begin
         outcome = (top_ff == token_ff) ? EV_MATCH : EV_REJECT;
      end else if (top_ff > SYM_F || token_ff > SYM_END || prod == P_BLANK) begin
         outcome = EV_REJECT;
      end else if (({1'b0, sp_ff} + (SPW + 1)'(n_len)) > DEPTH_P1) begin
         outcome = EV_OVERFLOW;
      end else if (n_len == 2'd0) begin
         outcome = EV_EPSILON;
      end else begin
         outcome = EV_EXPAND;
      end
   end

   always_comb begin
      sp_wide   = WW'(sp_ff);
      depth_sat = (sp_wide > WW'(127)) ? DEPTH_W'(127) : sp_wide[DEPTH_W-1:0];
   end

   always_comb begin
      sp_in        = sp_ff;
      finished_in  = finished_ff;
      last_in      = last_ff;
      rsp_valid_in = rsp_valid_ff;
      token_in     = token_ff;
      guard_in     = guard_ff;
      prod_in      = prod_ff;
      idx_in       = idx_ff;
      res_in       = res_ff;
      rsp_data_in  = rsp_data_ff;

      if (cmd.load) begin
         token_in  = req_token;
         guard_in  = '0;
      end
      if (cmd.init1) begin
         sp_in       = SPW'(2);
         finished_in = 1'b0;
         last_in     = ST_MATCH;
      end
      if (cmd.hold) res_in = last_ff;
      if (cmd.fault) begin
         res_in      = ST_REJECT;
         finished_in = 1'b1;
         last_in     = ST_REJECT;
      end
      if (cmd.eval) begin
         unique case (outcome)
            EV_MATCH: begin
               sp_in  = sp_m1;
               res_in = ST_MATCH;
            end
            EV_ACCEPT, EV_REJECT, EV_OVERFLOW: begin
               res_in      = (outcome == EV_ACCEPT) ? ST_ACCEPT :
                             (outcome == EV_OVERFLOW) ? ST_OVERFLOW : ST_REJECT;
               finished_in = 1'b1;
               last_in     = res_in;
            end
            default: begin
               sp_in    = sp_m1;
               guard_in = guard_ff + GUARD_W'(1);
               prod_in  = prod;
               idx_in   = n_len;
            end
         endcase
      end
      if (cmd.push) begin
         sp_in  = sp_ff + SPW'(1);
         idx_in = idx_ff - 2'd1;
      end
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = RSP_DATA_W'({depth_sat, res_ff});
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sp_ff        <= SPW'(2);
         finished_ff  <= 1'b0;
         last_ff      <= ST_MATCH;
         rsp_valid_ff <= 1'b0;
      end else begin
         sp_ff        <= sp_in;
         finished_ff  <= finished_in;
         last_ff      <= last_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      token_ff    <= token_in;
      guard_ff    <= guard_in;
      prod_ff     <= prod_in;
      idx_ff      <= idx_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_comb begin
      stat.finished   = finished_ff;
      stat.fault      = (guard_ff == GUARD_LIMIT) || (sp_ff == '0) || (sp_ff > DEPTH_MAX);
      stat.outcome    = outcome;
      stat.push_last  = (idx_ff == 2'd1);
      stat.out_free   = !rsp_valid_ff || rsp_tready;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule
`default_nettype wire

### rtl/core/ll1_expression_parser.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ll1_expression_parser
// Table-driven LL(1) parser for + - * / ( ) expressions over one operand a.
// ----------------------------------------------------------------------------
// Usage: one token per req transfer, one status per rsp transfer, in order.
// req_tuser[0] set starts a new string: the stack is rebuilt to $ E first.
// After accept, reject or overflow, tokens are ignored (the held final
// status and current depth repeat) until a new string is started.
// Timing: one token is taken only when the previous one has finished its
// walk through the stack. Each nonterminal on top is fetched and evaluated,
// then the symbols of its right-hand side (0 to 3) are pushed one by one;
// the terminal on top is fetched and evaluated, and the result register is
// loaded at the end of the walk. After each token, req_tready rises
// together with rsp_tvalid.
// Reset: synchronous; an init pass writes $ E into the stack, with
// req_tready low. When rsp_tready is low the result stays in the output
// register; the next token is still accepted and held until it frees up.
// ----------------------------------------------------------------------------
module ll1_expression_parser
   import ll1ep_pkg::*;
#(
   parameter int STACK_DEPTH = STACK_DEPTH_DEF
)(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   input  wire logic [REQ_DATA_W-1:0]  req_tdata,   // [3:0] token
   input  wire logic [0:0]             req_tuser,   // [0] new_string
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   output logic [RSP_DATA_W-1:0]       rsp_tdata    // [1:0] status, [8:2] stack_depth
);

   cmd_type  cmd;
   stat_type stat;

   ll1ep_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_new_string (req_tuser[0]),
      .stat           (stat),
      .cmd            (cmd)
   );

   ll1ep_datapath #(
      .STACK_DEPTH (STACK_DEPTH)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .req_token      (req_tdata[TOKEN_W-1:0]),
      .cmd            (cmd),
      .stat           (stat),
      .rsp_tready     (rsp_tready),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tdata      (rsp_tdata)
   );

endmodule
`default_nettype wire

### rtl/core/ll1ep_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ll1ep_checker
// Port-level checks of the expression parser, bound to the top level.
// ----------------------------------------------------------------------------
module ll1ep_checker
   import ll1ep_pkg::*;
(
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  req_tvalid,
   input wire logic                  req_tready,
   input wire logic                  rsp_tvalid,
   input wire logic                  rsp_tready,
   input wire logic [RSP_DATA_W-1:0] rsp_tdata
);

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp changed while stalled");

   // init pass keeps the input closed
   a_reset_closed: assert property (@(posedge clock)
      reset |=> !req_tready && !rsp_tvalid)
      else $error("ready or valid right after reset");

   // one token at a time
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("second token taken back to back");

   // acceptance leaves only the end marker
   a_accept_depth: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[1:0] == ST_ACCEPT |-> rsp_tdata[8:2] == 7'd1)
      else $error("accept with depth other than one");

endmodule

bind ll1_expression_parser ll1ep_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
`default_nettype wire
